FILE: sv/cgpsc_pkg.sv
// ----------------------------------------------------------------------------
// cgpsc_pkg
// Types, widths, register indexes and reset values of the cruise gap PID
// speed controller.
// ----------------------------------------------------------------------------
package cgpsc_pkg;

	localparam int GAP_W   = 16;
	localparam int SPEED_W = 15;
	localparam int GAIN_W  = 16;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;
	localparam int ERR_W   = 17;
	localparam int DER_W   = 18;
	localparam int SUM_W   = 32;
	localparam int PP_W    = GAIN_W + ERR_W;
	localparam int PI_W    = GAIN_W + SUM_W;
	localparam int PD_W    = GAIN_W + DER_W;
	localparam int ACC_W   = PI_W + 1;
	localparam int FRAC_W  = 12;
	localparam int TERM_W  = ACC_W - FRAC_W;
	localparam int SPD_X_W = TERM_W + 1;

	localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [IDX_W-1:0] REG_DESIRED_GAP = 3'd3;
	localparam logic [IDX_W-1:0] REG_SAFE_GAP    = 3'd4;
	localparam logic [IDX_W-1:0] REG_SET_SPEED   = 3'd5;
	localparam logic [IDX_W-1:0] REG_SPEED_LIMIT = 3'd6;

	localparam logic signed [GAIN_W-1:0] RST_GAIN_P      = 16'sd410;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_I      = 16'sd41;
	localparam logic signed [GAIN_W-1:0] RST_GAIN_D      = 16'sd82;
	localparam logic [GAP_W-1:0]         RST_DESIRED_GAP = 16'd5120;
	localparam logic [GAP_W-1:0]         RST_SAFE_GAP    = 16'd6400;
	localparam logic [SPEED_W-1:0]       RST_SET_SPEED   = 15'd25600;
	localparam logic [SPEED_W-1:0]       RST_SPEED_LIMIT = 15'd30720;

	typedef struct packed {
		logic [GAP_W-1:0]   gap;
		logic [SPEED_W-1:0] own_speed;
	} in_t;

	typedef struct packed {
		logic [SPEED_W-1:0] new_speed;
		logic               following;
	} out_t;

endpackage

FILE: sv/cruise_gap_pid_speed_control.sv
// ----------------------------------------------------------------------------
// cruise_gap_pid_speed_control
// Adaptive cruise speed step: picks distance or speed error, runs one shared
// PID with a saturating error sum and clamps the commanded speed.
// ----------------------------------------------------------------------------
// One result per measurement, one measurement per cycle sustained while the
// output is not stalled. The first stage forms the error and updates the
// error sum and previous error, the second runs the three gain multiplies,
// the third sums, rounds and clamps into the output register. Every stage
// holds while the output is stalled. Configuration writes are taken at any
// time and must only be issued while the block is empty.
module cruise_gap_pid_speed_control (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cgpsc_pkg::in_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cgpsc_pkg::out_t                 out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cgpsc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [cgpsc_pkg::DATA_W-1:0]    cfg_data
);

	logic signed [cgpsc_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [cgpsc_pkg::GAP_W-1:0]         desired_gap_q, safe_gap_q;
	logic [cgpsc_pkg::SPEED_W-1:0]       set_speed_q, speed_limit_q;

	logic signed [cgpsc_pkg::SUM_W-1:0]  error_sum_q;
	logic signed [cgpsc_pkg::ERR_W-1:0]  last_error_q;

	logic                                v_s1, v_s2, v_s3;
	logic                                rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic                                adv_s1;

	logic [cgpsc_pkg::GAP_W-1:0]         gap_s1;
	logic [cgpsc_pkg::SPEED_W-1:0]       own_s1, own_s2, own_s3;
	logic                                follow_s2, follow_s3;
	logic signed [cgpsc_pkg::ERR_W-1:0]  err_s2;
	logic signed [cgpsc_pkg::SUM_W-1:0]  sum_s2;
	logic signed [cgpsc_pkg::DER_W-1:0]  der_s2;
	logic signed [cgpsc_pkg::PP_W-1:0]   pp_s3;
	logic signed [cgpsc_pkg::PI_W-1:0]   pi_s3;
	logic signed [cgpsc_pkg::PD_W-1:0]   pd_s3;

	logic                                follow_d;
	logic signed [cgpsc_pkg::ERR_W-1:0]  err_d;
	logic signed [cgpsc_pkg::SUM_W:0]    sum_wide_d;
	logic signed [cgpsc_pkg::SUM_W-1:0]  sum_d;
	logic signed [cgpsc_pkg::DER_W-1:0]  der_d;
	logic signed [cgpsc_pkg::PP_W-1:0]   pp_d;
	logic signed [cgpsc_pkg::PI_W-1:0]   pi_d;
	logic signed [cgpsc_pkg::PD_W-1:0]   pd_d;
	logic signed [cgpsc_pkg::ACC_W-1:0]  acc_d;
	logic signed [cgpsc_pkg::TERM_W-1:0] term_d;
	logic signed [cgpsc_pkg::SPD_X_W-1:0] speed_d;
	logic [cgpsc_pkg::SPEED_W-1:0]       new_speed_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= cgpsc_pkg::RST_GAIN_P;
			gain_i_q      <= cgpsc_pkg::RST_GAIN_I;
			gain_d_q      <= cgpsc_pkg::RST_GAIN_D;
			desired_gap_q <= cgpsc_pkg::RST_DESIRED_GAP;
			safe_gap_q    <= cgpsc_pkg::RST_SAFE_GAP;
			set_speed_q   <= cgpsc_pkg::RST_SET_SPEED;
			speed_limit_q <= cgpsc_pkg::RST_SPEED_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cgpsc_pkg::REG_GAIN_P:      gain_p_q      <= $signed(cfg_data);
				cgpsc_pkg::REG_GAIN_I:      gain_i_q      <= $signed(cfg_data);
				cgpsc_pkg::REG_GAIN_D:      gain_d_q      <= $signed(cfg_data);
				cgpsc_pkg::REG_DESIRED_GAP: desired_gap_q <= cfg_data;
				cgpsc_pkg::REG_SAFE_GAP:    safe_gap_q    <= cfg_data;
				cgpsc_pkg::REG_SET_SPEED:   set_speed_q   <= cfg_data[cgpsc_pkg::SPEED_W-1:0];
				cgpsc_pkg::REG_SPEED_LIMIT: speed_limit_q <= cfg_data[cgpsc_pkg::SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign rdy_out  = !out_valid || out_ready;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign adv_s1   = v_s1 && rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				out_valid <= v_s3;
			end
		end
	end

	always_comb begin
		follow_d = gap_s1 < safe_gap_q;
		if (follow_d) begin
			err_d = $signed({1'b0, gap_s1}) - $signed({1'b0, desired_gap_q});
		end else begin
			err_d = $signed({2'b00, set_speed_q}) - $signed({2'b00, own_s1});
		end
		sum_wide_d = $signed({error_sum_q[cgpsc_pkg::SUM_W-1], error_sum_q})
			+ (cgpsc_pkg::SUM_W + 1)'(err_d);
		if (sum_wide_d[cgpsc_pkg::SUM_W] != sum_wide_d[cgpsc_pkg::SUM_W-1]) begin
			sum_d = sum_wide_d[cgpsc_pkg::SUM_W] ?
				{1'b1, {(cgpsc_pkg::SUM_W-1){1'b0}}} :
				{1'b0, {(cgpsc_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_d = sum_wide_d[cgpsc_pkg::SUM_W-1:0];
		end
		der_d = cgpsc_pkg::DER_W'(err_d) - cgpsc_pkg::DER_W'(last_error_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (adv_s1) begin
			error_sum_q  <= sum_d;
			last_error_q <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			gap_s1 <= in_data.gap;
			own_s1 <= in_data.own_speed;
		end
		if (adv_s1) begin
			err_s2    <= err_d;
			sum_s2    <= sum_d;
			der_s2    <= der_d;
			own_s2    <= own_s1;
			follow_s2 <= follow_d;
		end
		if (rdy_s3 && v_s2) begin
			pp_s3     <= pp_d;
			pi_s3     <= pi_d;
			pd_s3     <= pd_d;
			own_s3    <= own_s2;
			follow_s3 <= follow_s2;
		end
		if (rdy_out && v_s3) begin
			out_data.new_speed <= new_speed_d;
			out_data.following <= follow_s3;
		end
	end

	assign pp_d = cgpsc_pkg::PP_W'(gain_p_q) * cgpsc_pkg::PP_W'(err_s2);
	assign pi_d = cgpsc_pkg::PI_W'(gain_i_q) * cgpsc_pkg::PI_W'(sum_s2);
	assign pd_d = cgpsc_pkg::PD_W'(gain_d_q) * cgpsc_pkg::PD_W'(der_s2);

	always_comb begin
		acc_d = cgpsc_pkg::ACC_W'(pp_s3) + cgpsc_pkg::ACC_W'(pi_s3)
			+ cgpsc_pkg::ACC_W'(pd_s3) + cgpsc_pkg::ACC_W'(2048);
		term_d  = acc_d[cgpsc_pkg::ACC_W-1:cgpsc_pkg::FRAC_W];
		speed_d = $signed({{(cgpsc_pkg::SPD_X_W-cgpsc_pkg::SPEED_W){1'b0}}, own_s3})
			+ cgpsc_pkg::SPD_X_W'(term_d);
		priority if (speed_d[cgpsc_pkg::SPD_X_W-1]) begin
			new_speed_d = '0;
		end else if (speed_d > $signed({{(cgpsc_pkg::SPD_X_W-cgpsc_pkg::SPEED_W){1'b0}},
			speed_limit_q})) begin
			new_speed_d = speed_limit_q;
		end else begin
			new_speed_d = speed_d[cgpsc_pkg::SPEED_W-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	// The controller state moves only when an item leaves the first stage.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(error_sum_q) && $stable(last_error_q))
		else $error("PID state changed without a transfer out of stage one");

	// An empty first stage never blocks the input.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

	// A stalled middle stage keeps its operands.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_s3 |=> v_s2 && $stable(err_s2) && $stable(sum_s2))
		else $error("stage two lost its operands under a stall");

	// The clamp bounds the commanded speed by the limit.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> new_speed_d <= speed_limit_q)
		else $error("commanded speed above the speed limit");
`endif

endmodule
